### rtl/gwo_pkg.sv
// Shared package of the gated waveform oscillator: codes, default sizes,
// the stage-one control bundle and the sine series used to build the ROM.
// Depends on nothing; every other file refers to it by scoped names.
package gwo_pkg;

    localparam int PHASE_BITS_DEF     = 32;
    localparam int SINE_ADDR_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF    = 16;

    localparam int ACTION_BITS   = 2;
    localparam int IN_PHASE_BITS = 32;
    localparam int STEP_BITS     = 32;
    localparam int WAVE_BITS     = 2;
    localparam int AMP_BITS      = 16;
    localparam int AMP_FRAC      = 15;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [ACTION_BITS-1:0] ACT_RENDER  = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_TRIGGER = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_RELEASE = 2'd2;
    localparam logic [ACTION_BITS-1:0] ACT_LOAD    = 2'd3;

    localparam logic [WAVE_BITS-1:0] WAVE_SINE     = 2'd0;
    localparam logic [WAVE_BITS-1:0] WAVE_SQUARE   = 2'd1;
    localparam logic [WAVE_BITS-1:0] WAVE_TRIANGLE = 2'd2;
    localparam logic [WAVE_BITS-1:0] WAVE_SILENT   = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_WAVEFORM   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AMPLITUDE  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE_STEP = 2'd2;

    localparam logic [WAVE_BITS-1:0] WAVEFORM_RESET  = WAVE_SINE;
    localparam logic [AMP_BITS-1:0]  AMPLITUDE_RESET = 16'h8000;

    // Odd Taylor coefficients of the sine in Q30, lowest order first.
    localparam logic [63:0] SINE_COEF [0:6] = '{
        64'd1686629713, 64'd693598669, 64'd85569306, 64'd5026994,
        64'd172272, 64'd3864, 64'd61
    };

    typedef struct packed {
        logic gate;
        logic neg;
        logic sine;
    } t_s1_ctrl;

    // Q30 value of sin(pi/2 * j / 2^addr_bits), evaluated at elaboration only.
    function automatic logic [63:0] gwo_sine_q30(input logic [63:0] j, input int addr_bits);
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] acc;
        int k;
        t = j << (30 - addr_bits);
        u = (t * t) >> 30;
        acc = SINE_COEF[6];
        for (k = 5; k >= 0; k--) begin
            acc = SINE_COEF[k] - ((acc * u) >> 30);
        end
        return (acc * t) >> 30;
    endfunction

endpackage

### rtl/gwo_in_if.sv
// Input channel of the gated waveform oscillator: valid, ready and one item.
// Depends on gwo_pkg for the field widths.
interface gwo_in_if;
    logic                                valid;
    logic                                ready;
    logic [gwo_pkg::ACTION_BITS-1:0]     action;
    logic [gwo_pkg::IN_PHASE_BITS-1:0]   phase_value;

    modport source (output valid, output action, output phase_value, input ready);
    modport sink (input valid, input action, input phase_value, output ready);
endinterface

### rtl/gwo_out_if.sv
// Output channel of the gated waveform oscillator: valid, ready and one item.
// Depends on gwo_pkg for the default sample width.
interface gwo_out_if #(
    parameter int SAMPLE_BITS = gwo_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          gate_open;

    modport source (output valid, output sample, output gate_open, input ready);
    modport sink (input valid, input sample, input gate_open, output ready);
endinterface

### rtl/gwo_sine_rom.sv
// Quarter-wave sine ROM with a registered read port, filled at elaboration.
// Depends on gwo_pkg for the sine series.
module gwo_sine_rom #(
    parameter int SINE_TABLE_ADDR_BITS = gwo_pkg::SINE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS          = gwo_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [SINE_TABLE_ADDR_BITS:0] i_idx,
    output logic [SAMPLE_BITS:0]          o_data
);

    localparam int DEPTH = (1 << SINE_TABLE_ADDR_BITS) + 1;

    typedef logic [SAMPLE_BITS:0] t_rom [0:DEPTH-1];

    function automatic t_rom f_build();
        t_rom        rom;
        logic [63:0] q30;
        logic [63:0] full;
        int          j;
        full = 64'd1 << (SAMPLE_BITS - 1);
        for (j = 0; j < DEPTH; j++) begin
            q30 = gwo_pkg::gwo_sine_q30(64'(j), SINE_TABLE_ADDR_BITS);
            rom[j] = (SAMPLE_BITS + 1)'((q30 * full + (64'd1 << 29)) >> 30);
        end
        return rom;
    endfunction

    localparam t_rom ROM = f_build();

    logic [SAMPLE_BITS:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= ROM[i_idx];
        end
    end

    assign o_data = r_data;

endmodule

### rtl/gwo_front.sv
// Phase accumulator, gate flag and first pipeline stage: ROM address,
// square and triangle values. Depends on gwo_pkg.
module gwo_front #(
    parameter int PHASE_BITS           = gwo_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_ADDR_BITS = gwo_pkg::SINE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS          = gwo_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic                               i_load,
    input  logic [gwo_pkg::ACTION_BITS-1:0]    i_action,
    input  logic [gwo_pkg::IN_PHASE_BITS-1:0]  i_phase_value,
    input  logic [gwo_pkg::STEP_BITS-1:0]      i_phase_step,
    input  logic [gwo_pkg::WAVE_BITS-1:0]      i_waveform,
    output logic [SINE_TABLE_ADDR_BITS:0]      o_rom_idx,
    output logic                               o_valid,
    output gwo_pkg::t_s1_ctrl                  o_ctrl,
    output logic signed [SAMPLE_BITS:0]        o_lin
);

    localparam int A = SINE_TABLE_ADDR_BITS;
    localparam int S = SAMPLE_BITS;
    localparam int P = PHASE_BITS;

    localparam logic [A:0]          ROM_TOP = {1'b1, {A{1'b0}}};
    localparam logic signed [S:0]   FULL    = {2'b01, {(S-1){1'b0}}};
    localparam logic signed [S+2:0] TWO_F   = {3'b001, {S{1'b0}}};
    localparam logic signed [S+2:0] FOUR_F  = {2'b01, {(S+1){1'b0}}};

    logic [P-1:0]      r_phase;
    logic [P-1:0]      n_phase;
    logic              r_gate;
    logic              n_gate;
    logic              r_valid;
    gwo_pkg::t_s1_ctrl r_ctrl;
    gwo_pkg::t_s1_ctrl n_ctrl;
    logic signed [S:0] r_lin;
    logic signed [S:0] n_lin;

    logic [1:0]        quad;
    logic [A-1:0]      idx;
    logic [P+31:0]     wide_pv;
    logic [P+31:0]     wide_step;
    logic [P+S:0]      wide_x;
    logic [S:0]        tri_x;
    logic signed [S+2:0] x_ext;
    logic signed [S+2:0] tri_val;

    always_comb begin
        quad      = r_phase[P-1 -: 2];
        idx       = r_phase[P-3 -: A];
        o_rom_idx = quad[0] ? (ROM_TOP - {1'b0, idx}) : {1'b0, idx};

        wide_pv   = {i_phase_value, {P{1'b0}}};
        wide_step = {i_phase_step, {P{1'b0}}};

        wide_x  = {r_phase, {(S+1){1'b0}}};
        tri_x   = wide_x[P+S:P];
        x_ext   = signed'({2'b00, tri_x});
        case (quad)
            2'd0:    tri_val = x_ext;
            2'd1:    tri_val = TWO_F - x_ext;
            2'd2:    tri_val = TWO_F - x_ext;
            default: tri_val = x_ext - FOUR_F;
        endcase

        case (i_waveform)
            gwo_pkg::WAVE_SQUARE:   n_lin = quad[1] ? -FULL : FULL;
            gwo_pkg::WAVE_TRIANGLE: n_lin = tri_val[S:0];
            default:                n_lin = '0;
        endcase

        n_ctrl.gate = r_gate;
        n_ctrl.neg  = quad[1];
        n_ctrl.sine = (i_waveform == gwo_pkg::WAVE_SINE);

        n_phase = r_phase;
        n_gate  = r_gate;
        if (i_accept) begin
            case (i_action)
                gwo_pkg::ACT_RENDER: begin
                    if (r_gate) begin
                        n_phase = r_phase + wide_step[P+31:32];
                    end
                end
                gwo_pkg::ACT_TRIGGER: n_gate  = 1'b1;
                gwo_pkg::ACT_RELEASE: n_gate  = 1'b0;
                gwo_pkg::ACT_LOAD:    n_phase = wide_pv[P+31:32];
                default:              n_phase = r_phase;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_gate  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_gate  <= n_gate;
            if (i_load) begin
                r_valid <= i_accept && (i_action == gwo_pkg::ACT_RENDER);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ctrl <= n_ctrl;
            r_lin  <= n_lin;
        end
    end

    assign o_valid = r_valid;
    assign o_ctrl  = r_ctrl;
    assign o_lin   = r_lin;

endmodule

### rtl/gwo_back.sv
// Second pipeline stage and result register: sine sign, amplitude gain,
// rounding and saturation. Depends on gwo_pkg.
module gwo_back #(
    parameter int SAMPLE_BITS = gwo_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  gwo_pkg::t_s1_ctrl              i_ctrl,
    input  logic signed [SAMPLE_BITS:0]    i_lin,
    input  logic [SAMPLE_BITS:0]           i_rom,
    input  logic [gwo_pkg::AMP_BITS-1:0]   i_amplitude,
    input  logic                           i_ready,
    output logic                           o_advance,
    output logic                           o_valid,
    output logic signed [SAMPLE_BITS-1:0]  o_sample,
    output logic                           o_gate_open
);

    localparam int S  = SAMPLE_BITS;
    localparam int PW = S + 1 + gwo_pkg::AMP_BITS + 1;

    localparam logic signed [S+2:0] SAT_MAX = {4'b0000, {(S-1){1'b1}}};
    localparam logic signed [S+2:0] SAT_MIN = {4'b1111, {(S-1){1'b0}}};
    localparam logic signed [PW-1:0] HALF   = PW'(1) << (gwo_pkg::AMP_FRAC - 1);

    logic                    r_valid;
    logic signed [S-1:0]     r_sample;
    logic signed [S-1:0]     n_sample;
    logic                    r_gate_open;

    logic signed [S:0]       sine_val;
    logic signed [S:0]       wave;
    logic signed [PW-1:0]    prod;
    logic signed [PW-1:0]    rounded;
    logic signed [S+2:0]     scaled;

    always_comb begin
        o_advance = !r_valid || i_ready;

        sine_val = signed'(i_rom);
        if (i_ctrl.sine) begin
            wave = i_ctrl.neg ? -sine_val : sine_val;
        end else begin
            wave = i_lin;
        end
        prod    = wave * signed'({1'b0, i_amplitude});
        rounded = prod + HALF;
        scaled  = rounded[gwo_pkg::AMP_FRAC +: S+3];

        if (!i_ctrl.gate) begin
            n_sample = '0;
        end else if (scaled > SAT_MAX) begin
            n_sample = SAT_MAX[S-1:0];
        end else if (scaled < SAT_MIN) begin
            n_sample = SAT_MIN[S-1:0];
        end else begin
            n_sample = scaled[S-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_sample    <= n_sample;
            r_gate_open <= i_ctrl.gate;
        end
    end

    assign o_valid     = r_valid;
    assign o_sample    = r_sample;
    assign o_gate_open = r_gate_open;

endmodule

### rtl/gated_waveform_oscillator.sv
// Top level of the gated waveform oscillator: configuration registers,
// pipeline flow control and the front, ROM and back stages.
// Depends on gwo_pkg, gwo_in_if, gwo_out_if, gwo_front, gwo_sine_rom, gwo_back.
//
//   Port      Direction   Carries
//   i_in      sink        action, phase_value
//   o_out     source      sample, gate_open
//   i_cfg_*   write only  waveform, amplitude, phase_step
//
// One item is accepted per cycle while the first stage can load; a render's result
// passes the first-stage and registered sine ROM read, then the result register.
// Reset is synchronous and clears the phase, the gate and both stage valids.
// A stalled result stage still lets one more item enter the first stage.
module gated_waveform_oscillator #(
    parameter int PHASE_BITS           = gwo_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_ADDR_BITS = gwo_pkg::SINE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS          = gwo_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    gwo_in_if.sink                             i_in,
    gwo_out_if.source                          o_out,
    input  logic                               i_cfg_we,
    input  logic [gwo_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [gwo_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    logic [gwo_pkg::WAVE_BITS-1:0] r_waveform;
    logic [gwo_pkg::AMP_BITS-1:0]  r_amplitude;
    logic [gwo_pkg::STEP_BITS-1:0] r_phase_step;

    logic                          w_load;
    logic                          w_accept;
    logic                          w_advance;
    logic [SINE_TABLE_ADDR_BITS:0] w_rom_idx;
    logic [SAMPLE_BITS:0]          w_rom_data;
    logic                          w_s1_valid;
    gwo_pkg::t_s1_ctrl             w_s1_ctrl;
    logic signed [SAMPLE_BITS:0]   w_s1_lin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waveform   <= gwo_pkg::WAVEFORM_RESET;
            r_amplitude  <= gwo_pkg::AMPLITUDE_RESET;
            r_phase_step <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gwo_pkg::CFG_WAVEFORM:   r_waveform   <= i_cfg_data[gwo_pkg::WAVE_BITS-1:0];
                gwo_pkg::CFG_AMPLITUDE:  r_amplitude  <= i_cfg_data[gwo_pkg::AMP_BITS-1:0];
                gwo_pkg::CFG_PHASE_STEP: r_phase_step <= i_cfg_data[gwo_pkg::STEP_BITS-1:0];
                default:                 r_phase_step <= r_phase_step;
            endcase
        end
    end

    assign w_load     = !w_s1_valid || w_advance;
    assign w_accept   = i_in.valid && w_load;
    assign i_in.ready = w_load;

    gwo_front #(
        .PHASE_BITS           (PHASE_BITS),
        .SINE_TABLE_ADDR_BITS (SINE_TABLE_ADDR_BITS),
        .SAMPLE_BITS          (SAMPLE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_load        (w_load),
        .i_action      (i_in.action),
        .i_phase_value (i_in.phase_value),
        .i_phase_step  (r_phase_step),
        .i_waveform    (r_waveform),
        .o_rom_idx     (w_rom_idx),
        .o_valid       (w_s1_valid),
        .o_ctrl        (w_s1_ctrl),
        .o_lin         (w_s1_lin)
    );

    gwo_sine_rom #(
        .SINE_TABLE_ADDR_BITS (SINE_TABLE_ADDR_BITS),
        .SAMPLE_BITS          (SAMPLE_BITS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (w_load),
        .i_idx  (w_rom_idx),
        .o_data (w_rom_data)
    );

    gwo_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_s1_valid),
        .i_ctrl      (w_s1_ctrl),
        .i_lin       (w_s1_lin),
        .i_rom       (w_rom_data),
        .i_amplitude (r_amplitude),
        .i_ready     (o_out.ready),
        .o_advance   (w_advance),
        .o_valid     (o_out.valid),
        .o_sample    (o_out.sample),
        .o_gate_open (o_out.gate_open)
    );

endmodule

### rtl/gwo_checker.sv
// Port-level checks of the gated waveform oscillator and their bind.
// Depends on gwo_pkg and on the ports of gated_waveform_oscillator.
module gwo_checker #(
    parameter int SAMPLE_BITS = gwo_pkg::SAMPLE_BITS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] i_sample,
    input logic                   i_gate_open
);

    // A stalled result keeps its item.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_sample)
            && $stable(i_gate_open))
        else $error("result item changed while stalled");

    // A closed gate always renders silence.
    a_gate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_gate_open |-> i_sample == '0)
        else $error("nonzero sample with the gate closed");

    // The input side only waits behind a full, stalled result register.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input not ready without output backpressure");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // An offered input item only waits while a result is held.
    a_accept_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_ready |-> i_out_valid)
        else $error("input stalled while the result register is empty");

endmodule

bind gated_waveform_oscillator gwo_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_gwo_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_sample    (o_out.sample),
    .i_gate_open (o_out.gate_open)
);
